// File: rtl/learning_switch_forwarder_core_assert.svh
// Assertion macros for the learning switch forwarder.
`ifndef LEARNING_SWITCH_FORWARDER_CORE_ASSERT_SVH
`define LEARNING_SWITCH_FORWARDER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LSF_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define LSF_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`else
`define LSF_ASSERT(label, cond, msg)
`define LSF_ASSERT_IMP(label, pre, post, msg)
`endif
`endif

// File: rtl/lsf_pkg.sv
// Shared types and constants of the learning switch forwarder.
package lsf_pkg;
	localparam int MaxPorts = 16;
	localparam int TableEntries = 64;
	localparam int IdxW = $clog2(TableEntries);
	localparam int PortW = 4;
	localparam logic [15:0] MinFrameBytes = 16'd14;
	localparam logic [1:0] VerdictReject = 2'd0;
	localparam logic [1:0] VerdictFlood = 2'd1;
	localparam logic [1:0] VerdictForward = 2'd2;
	localparam logic [1:0] VerdictSelf = 2'd3;
	localparam logic [1:0] LearnNone = 2'd0;
	localparam logic [1:0] LearnNew = 2'd1;
	localparam logic [1:0] LearnMoved = 2'd2;
	localparam logic [1:0] LearnKnown = 2'd3;
	localparam logic CfgUplink = 1'b0;
	localparam logic CfgPorts = 1'b1;

	typedef struct packed {
		logic [4:0]  source_port;
		logic [47:0] dest_address;
		logic [47:0] source_address;
		logic [15:0] frame_length;
	} req_t;

	typedef struct packed {
		logic [15:0] port_mask;
		logic        uplink_flag;
		logic [1:0]  verdict_kind;
		logic [1:0]  learn_kind;
	} rsp_t;

	typedef struct packed {
		logic            wr;
		logic [IdxW-1:0] idx;
		logic [47:0]     addr;
		logic [PortW-1:0] port;
	} tbl_wr_t;
endpackage

// File: rtl/lsf_stream_if.sv
// Valid-ready channel interface.
interface lsf_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: rtl/lsf_table.sv
// MAC table memory with one write port, one registered read port and valid bits.
module lsf_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lsf_pkg::IdxW-1:0]     rd_idx,
	output logic                         rd_valid,
	output logic [47:0]                  rd_addr,
	output logic [lsf_pkg::PortW-1:0]    rd_port,
	input  lsf_pkg::tbl_wr_t             wr
);
	logic [47:0] addr_mem [lsf_pkg::TableEntries];
	logic [lsf_pkg::PortW-1:0] port_mem [lsf_pkg::TableEntries];
	logic [lsf_pkg::TableEntries-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr.wr) begin
			addr_mem[wr.idx] <= wr.addr;
			port_mem[wr.idx] <= wr.port;
		end
		rd_addr <= addr_mem[rd_idx];
		rd_port <= port_mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_valid <= 1'b0;
		end else begin
			if (wr.wr) valid_q[wr.idx] <= 1'b1;
			rd_valid <= valid_q[rd_idx];
		end
	end
endmodule

// File: rtl/learning_switch_forwarder_core.sv
// Top level of the learning switch forwarder.
// One frame header enters on req (a transfer when valid and ready are high) and
// one verdict leaves on rsp. Configuration is written through cfg_we, cfg_index
// and cfg_data; the user must write it only while the block is idle, as the
// block does not enforce this. Index 0 enables the uplink, index 1 sets the
// member count, saturated to 16. A valid header is handled in two sweeps over
// the 64-entry table, one entry a cycle through the single read port of the
// table memory. The first sweep learns the source address, then the write state
// writes the table unless the address is known on that port, and the second
// sweep looks up the destination. With a group source the first sweep and the
// write are skipped, and a rejected header goes straight to the output state.
// Only one header is in flight at a time.
// The verdict is held in an output register until rsp.ready takes it; no new
// header is accepted until then, and the next one can be taken in the cycle
// after the verdict transfer.
// Reset clears the valid bits of the table, the eviction pointer and the control
// registers at once; no clearing pass is needed.
`include "learning_switch_forwarder_core_assert.svh"
module learning_switch_forwarder_core (
	input  logic        clk,
	input  logic        arst_n,
	lsf_stream_if.sink   req,
	lsf_stream_if.source rsp,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_LEARN = 6'b000010,
		ST_WRITE = 6'b000100,
		ST_LOOK  = 6'b001000,
		ST_DONE  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	localparam int IW = lsf_pkg::IdxW;

	state_t state_q;
	lsf_pkg::req_t hdr_q;
	logic uplink_q;
	logic [4:0] ports_q;
	logic [IW:0] scan_q;
	logic [IW:0] cmp_q;
	logic hit_q, free_q;
	logic [IW-1:0] hit_idx_q, free_idx_q, evict_q;
	logic [lsf_pkg::PortW-1:0] hit_port_q;
	lsf_pkg::rsp_t res_q;
	logic out_valid_q;
	logic [4:0] count;

	logic rd_valid;
	logic [47:0] rd_addr;
	logic [lsf_pkg::PortW-1:0] rd_port;
	lsf_pkg::tbl_wr_t wr;
	logic [47:0] key;
	logic match;
	logic [15:0] flood;
	logic ok;

	assign count = (ports_q > 5'(lsf_pkg::MaxPorts)) ? 5'(lsf_pkg::MaxPorts) : ports_q;
	assign ok = (req.payload.frame_length >= lsf_pkg::MinFrameBytes)
		&& (req.payload.source_port < count);
	assign key = (state_q == ST_LEARN) ? hdr_q.source_address : hdr_q.dest_address;
	assign match = rd_valid && (rd_addr == key) && scan_q != '0 && !cmp_q[IW];

	always_comb begin
		flood = '0;
		for (int i = 0; i < 16; i++)
			if (5'(i) < count && 5'(i) != hdr_q.source_port) flood[i] = 1'b1;
	end

	lsf_table u_table (
		.clk(clk), .arst_n(arst_n), .rd_idx(scan_q[IW-1:0]),
		.rd_valid(rd_valid), .rd_addr(rd_addr), .rd_port(rd_port), .wr(wr)
	);

	always_comb begin
		wr = '0;
		wr.addr = hdr_q.source_address;
		wr.port = hdr_q.source_port[lsf_pkg::PortW-1:0];
		if (state_q == ST_WRITE) begin
			wr.wr = 1'b1;
			if (hit_q) wr.idx = hit_idx_q;
			else if (free_q) wr.idx = free_idx_q;
			else wr.idx = evict_q;
			if (hit_q && hit_port_q == wr.port) wr.wr = 1'b0;
		end
	end

	assign req.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign rsp.valid = out_valid_q;
	assign rsp.payload = res_q;

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) hdr_q <= req.payload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			uplink_q <= 1'b0;
			ports_q <= '0;
			scan_q <= '0;
			cmp_q <= '0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			hit_idx_q <= '0;
			free_idx_q <= '0;
			evict_q <= '0;
			hit_port_q <= '0;
			res_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lsf_pkg::CfgUplink: uplink_q <= cfg_data[0];
					lsf_pkg::CfgPorts:  ports_q <= cfg_data;
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						res_q <= '0;
						scan_q <= '0;
						cmp_q <= '0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						if (!ok) state_q <= ST_OUT;
						else if (req.payload.source_address[40]) state_q <= ST_LOOK;
						else state_q <= ST_LEARN;
					end
				end
				ST_LEARN, ST_LOOK: begin
					if (scan_q != '0) cmp_q <= cmp_q + 1'b1;
					if (!scan_q[IW]) scan_q <= scan_q + 1'b1;
					if (scan_q != '0 && !cmp_q[IW]) begin
						if (match && !hit_q) begin
							hit_q <= 1'b1;
							hit_idx_q <= cmp_q[IW-1:0];
							hit_port_q <= rd_port;
						end
						if (!rd_valid && !free_q && state_q == ST_LEARN) begin
							free_q <= 1'b1;
							free_idx_q <= cmp_q[IW-1:0];
						end
					end
					if (cmp_q[IW]) begin
						if (state_q == ST_LEARN) state_q <= ST_WRITE;
						else state_q <= ST_DONE;
					end
				end
				ST_WRITE: begin
					if (hit_q) res_q.learn_kind <= (hit_port_q == wr.port)
						? lsf_pkg::LearnKnown : lsf_pkg::LearnMoved;
					else res_q.learn_kind <= lsf_pkg::LearnNew;
					if (!hit_q && !free_q) evict_q <= evict_q + 1'b1;
					hit_q <= 1'b0;
					scan_q <= '0;
					cmp_q <= '0;
					state_q <= ST_LOOK;
				end
				ST_DONE: begin
					if (!hdr_q.dest_address[40] && hit_q) begin
						if ({1'b0, hit_port_q} != hdr_q.source_port) begin
							res_q.port_mask <= 16'(1) << hit_port_q;
							res_q.verdict_kind <= lsf_pkg::VerdictForward;
						end else begin
							res_q.port_mask <= '0;
							res_q.verdict_kind <= lsf_pkg::VerdictSelf;
						end
						res_q.uplink_flag <= 1'b0;
					end else begin
						res_q.port_mask <= flood;
						res_q.uplink_flag <= uplink_q;
						res_q.verdict_kind <= lsf_pkg::VerdictFlood;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`LSF_ASSERT(a_onehot, $onehot(state_q), "state is not one-hot")
	`LSF_ASSERT_IMP(a_ready_idle, req.ready, state_q == ST_IDLE, "ready outside idle")
	`LSF_ASSERT_IMP(a_write_state, wr.wr, state_q == ST_WRITE, "table write outside write state")
	`LSF_ASSERT_IMP(a_out_hold, rsp.valid && !rsp.ready, ##1 rsp.valid, "result dropped")
endmodule

// File: test/learning_switch_forwarder_core_tb.sv
// Self-checking testbench of the learning switch forwarder: directed and random frame headers.
module learning_switch_forwarder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = lsf_pkg::CfgUplink;
	logic [4:0] cfg_data = '0;

	lsf_stream_if #(.T(lsf_pkg::req_t)) req();
	lsf_stream_if #(.T(lsf_pkg::rsp_t)) rsp();

	learning_switch_forwarder_core dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Mirror of the address table.
	logic        mac_valid [lsf_pkg::TableEntries];
	logic [47:0] mac_addr [lsf_pkg::TableEntries];
	logic [3:0]  mac_port [lsf_pkg::TableEntries];
	logic [5:0]  victim_ptr;
	logic        uplink_on;
	logic [4:0]  member_reg;

	lsf_pkg::req_t pending_frames[$];
	lsf_pkg::rsp_t expected_verdicts[$];
	int   failures = 0;
	int   verdicts_seen = 0;
	bit   drv_quiet = 0;
	bit   rcv_quiet = 0;
	int   hold_cycles = 0;
	int   floods = 0, forwards = 0, selfs = 0, rejects = 0;

	initial begin
		req.valid = 1'b0;
		req.payload = '0;
		rsp.ready = 1'b0;
	end

	function automatic logic [1:0] learn_source(logic [4:0] slot, logic [47:0] mac);
		int target;
		if (mac[40])
			return lsf_pkg::LearnNone;
		target = -1;
		for (int i = 0; i < lsf_pkg::TableEntries; i++) begin
			if (mac_valid[i] && mac_addr[i] == mac) begin
				if (mac_port[i] != slot[3:0]) begin
					mac_port[i] = slot[3:0];
					return lsf_pkg::LearnMoved;
				end
				return lsf_pkg::LearnKnown;
			end
			if (!mac_valid[i] && target < 0)
				target = i;
		end
		if (target < 0) begin
			target = victim_ptr;
			victim_ptr = victim_ptr + 6'd1;
		end
		mac_addr[target] = mac;
		mac_port[target] = slot[3:0];
		mac_valid[target] = 1'b1;
		return lsf_pkg::LearnNew;
	endfunction

	function automatic lsf_pkg::rsp_t forward_frame(lsf_pkg::req_t f);
		lsf_pkg::rsp_t r;
		int members;
		bit found;
		r = '0;
		members = member_reg > lsf_pkg::MaxPorts ? lsf_pkg::MaxPorts : member_reg;
		if (f.frame_length < lsf_pkg::MinFrameBytes || f.source_port >= members)
			return r;
		r.learn_kind = learn_source(f.source_port, f.source_address);
		found = 0;
		if (!f.dest_address[40]) begin
			for (int i = 0; i < lsf_pkg::TableEntries; i++) begin
				if (mac_valid[i] && mac_addr[i] == f.dest_address) begin
					found = 1;
					if (mac_port[i] != f.source_port[3:0]) begin
						r.port_mask = 16'd1 << mac_port[i];
						r.verdict_kind = lsf_pkg::VerdictForward;
					end else
						r.verdict_kind = lsf_pkg::VerdictSelf;
					break;
				end
			end
		end
		if (!found) begin
			for (int i = 0; i < members; i++)
				if (i != f.source_port)
					r.port_mask[i] = 1'b1;
			r.uplink_flag = uplink_on;
			r.verdict_kind = lsf_pkg::VerdictFlood;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (req.valid && req.ready)
			expected_verdicts.push_back(forward_frame(req.payload));
	end

	// Driver: offers the head of the queue; the payload only moves after a transfer.
	always @(posedge clk) begin
		automatic bit took = req.valid && req.ready;
		if (took)
			void'(pending_frames.pop_front());
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!(req.valid && !took)) begin
			if (pending_frames.size() > 0 && (drv_quiet || $urandom_range(99) >= 32)) begin
				req.valid <= 1'b1;
				req.payload <= pending_frames[0];
			end else
				req.valid <= 1'b0;
		end
	end

	// Receiver with random stalls and one long hold-off.
	always @(posedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp.ready <= 1'b0;
		end else
			rsp.ready <= rcv_quiet || $urandom_range(99) >= 32;
	end

	always @(posedge clk) begin
		lsf_pkg::rsp_t want;
		if (rsp.valid && rsp.ready) begin
			verdicts_seen++;
			if (expected_verdicts.size() == 0) begin
				$error("verdict with none expected: %h", rsp.payload);
				failures++;
			end else begin
				want = expected_verdicts.pop_front();
				case (want.verdict_kind)
					lsf_pkg::VerdictFlood: floods++;
					lsf_pkg::VerdictForward: forwards++;
					lsf_pkg::VerdictSelf: selfs++;
					default: rejects++;
				endcase
				if (rsp.payload.port_mask !== want.port_mask) begin
					$error("port_mask expected %h actual %h", want.port_mask,
						rsp.payload.port_mask);
					failures++;
				end
				if (rsp.payload.uplink_flag !== want.uplink_flag) begin
					$error("uplink_flag expected %b actual %b", want.uplink_flag,
						rsp.payload.uplink_flag);
					failures++;
				end
				if (rsp.payload.verdict_kind !== want.verdict_kind) begin
					$error("verdict_kind expected %0d actual %0d", want.verdict_kind,
						rsp.payload.verdict_kind);
					failures++;
				end
				if (rsp.payload.learn_kind !== want.learn_kind) begin
					$error("learn_kind expected %0d actual %0d", want.learn_kind,
						rsp.payload.learn_kind);
					failures++;
				end
			end
		end
	end

	task automatic drain();
		while (pending_frames.size() > 0 || expected_verdicts.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] index, logic [4:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (index == lsf_pkg::CfgUplink)
			uplink_on = value[0];
		else
			member_reg = value;
	endtask

	function automatic logic [47:0] pick_mac(bit group);
		logic [47:0] m;
		m = 48'({$urandom, $urandom});
		if ($urandom_range(3) != 0)
			m = {40'h02_00_00_00_00, 8'($urandom_range(95))};
		m[40] = group;
		return m;
	endfunction

	function automatic lsf_pkg::req_t make_frame(int members);
		lsf_pkg::req_t f;
		int pick;
		pick = $urandom_range(99);
		f.source_port = (members > 0 && pick < 92) ? 5'($urandom_range(members - 1))
			: 5'($urandom);
		f.dest_address = pick_mac($urandom_range(9) == 0);
		f.source_address = pick_mac($urandom_range(19) == 0);
		f.frame_length = pick < 95 ? 16'($urandom_range(65535, 14)) : 16'($urandom_range(13));
		return f;
	endfunction

	initial begin
		lsf_pkg::req_t f;
		int members;
		for (int i = 0; i < lsf_pkg::TableEntries; i++)
			mac_valid[i] = 1'b0;
		victim_ptr = '0;
		uplink_on = 1'b0;
		member_reg = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: with no members everything is rejected.
		pending_frames.push_back('{5'd0, 48'h0200_0000_0001, 48'h0200_0000_0002, 16'd64});
		drain();
		write_reg(lsf_pkg::CfgPorts, 5'd16);
		write_reg(lsf_pkg::CfgUplink, 1'b1);
		pending_frames.push_back('{5'd0, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000, 16'd14});
		pending_frames.push_back('{5'd3, 48'h0000_0000_0000, 48'hFEFF_FFFF_FFFF, 16'hFFFF});
		pending_frames.push_back('{5'd15, 48'h0000_0000_0000, 48'h0000_0000_0000, 16'd60});
		pending_frames.push_back('{5'd3, 48'h0000_0000_0000, 48'h0000_0000_0000, 16'd60});
		pending_frames.push_back('{5'd3, 48'hFEFF_FFFF_FFFF, 48'h0100_0000_0000, 16'd60});
		pending_frames.push_back('{5'd3, 48'h0000_0000_0000, 48'h0200_0000_0009, 16'd13});
		pending_frames.push_back('{5'd16, 48'h0000_0000_0000, 48'h0200_0000_0009, 16'd60});
		pending_frames.push_back('{5'd31, 48'h0000_0000_0000, 48'h0200_0000_0009, 16'd60});
		pending_frames.push_back('{5'd7, 48'h0200_0000_0077, 48'hFFFF_FFFF_FFFF, 16'd0});
		drain();
		write_reg(lsf_pkg::CfgPorts, 5'd31);
		write_reg(lsf_pkg::CfgUplink, 1'b0);
		pending_frames.push_back('{5'd15, 48'hFFFF_FFFF_FFFF, 48'h0200_0000_00AA, 16'd20});
		// Fill the table past its size to force round-robin eviction.
		for (int i = 0; i < 70; i++)
			pending_frames.push_back('{5'(i % 16), 48'h0000_0000_0000,
				48'h0A00_0000_0000 + i, 16'd64});
		drain();
		write_reg(lsf_pkg::CfgPorts, 5'd1);
		pending_frames.push_back('{5'd0, 48'h0A00_0000_0045, 48'h0A00_0000_0045, 16'd64});
		pending_frames.push_back('{5'd0, 48'h0100_5E00_0001, 48'h0200_0000_0001, 16'd64});
		drain();

		// Random phases over several settings; the long hold-off comes in the first one.
		for (int phase = 0; phase < 8; phase++) begin
			members = phase == 7 ? 0 : $urandom_range(16);
			if (phase == 1) members = 16;
			write_reg(lsf_pkg::CfgPorts, phase == 2 ? 5'd31 : 5'(members));
			if (phase == 2) members = 16;
			write_reg(lsf_pkg::CfgUplink, 1'($urandom));
			drv_quiet = phase == 3;
			rcv_quiet = phase == 3;
			if (phase == 0)
				hold_cycles = 3000;
			for (int i = 0; i < (phase == 7 ? 50 : 270); i++) begin
				f = make_frame(members);
				pending_frames.push_back(f);
			end
			drain();
		end
		$display("Checked %0d verdicts: %0d flooded, %0d forwarded, %0d self-dropped, %0d rejected.",
			verdicts_seen, floods, forwards, selfs, rejects);
		$display("Member counts from 0 to 31 and both uplink settings were exercised.");
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#40ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule
